/* hdl/hce_pkg.sv */
package hce_pkg;

   // Buffer geometry; every width below follows from the depth (range 1 to 63)
   localparam int BUFFER_DEPTH = 32;
   localparam int FILL_W       = $clog2(BUFFER_DEPTH + 1);
   localparam int ADDR_W       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int NIB_COUNT    = (FILL_W + 3) / 4;
   localparam int NIB_W        = (NIB_COUNT > 1) ? $clog2(NIB_COUNT) : 1;
   localparam int HEX_W        = NIB_COUNT * 4;

   localparam int KIND_W  = 2;
   localparam int BYTE_W  = 8;
   localparam int LIMIT_W = 6;

   localparam logic [LIMIT_W-1:0] CHUNK_LIMIT_RESET = 6'd32;

   localparam logic [BYTE_W-1:0] ASCII_CR      = 8'h0D;
   localparam logic [BYTE_W-1:0] ASCII_LF      = 8'h0A;
   localparam logic [BYTE_W-1:0] ASCII_ZERO    = 8'h30;
   localparam logic [BYTE_W-1:0] ASCII_UPPER_A = 8'h41;

   typedef enum logic [KIND_W-1:0] {
      KIND_DATA   = 2'd0,
      KIND_FLUSH  = 2'd1,
      KIND_FINISH = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HEX,
      ST_CR1,
      ST_LF1,
      ST_DATA,
      ST_CR2,
      ST_LF2,
      ST_ZERO,
      ST_CR3,
      ST_LF3
   } hce_state_type;

   typedef enum logic [2:0] {
      SEL_HEX,
      SEL_CR,
      SEL_LF,
      SEL_DATA,
      SEL_ZERO
   } byte_sel_type;

   typedef enum logic [1:0] {
      FILL_HOLD,
      FILL_ADD_REQ,
      FILL_CLEAR,
      FILL_RESTART_PEND
   } fill_op_type;

   typedef struct packed {
      logic         emit;
      byte_sel_type byte_sel;
      logic         last;
      fill_op_type  fill_op;
      logic         capture;
      logic         start_chunk;
      logic         nib_dec;
      logic         idx_inc;
   } hce_cmd_type;

   typedef struct packed {
      logic out_free;
      logic fill_zero;
      logic need_flush;
      logic nib_zero;
      logic data_last;
   } hce_status_type;

   // Upper-case hex character for one nibble
   function automatic logic [BYTE_W-1:0] hex_ascii(input logic [3:0] nib);
      logic [BYTE_W-1:0] code;
      if (nib < 4'd10) begin
         code = ASCII_ZERO + {4'h0, nib};
      end else begin
         code = ASCII_UPPER_A + {4'h0, nib} - 8'd10;
      end
      return code;
   endfunction

endpackage

/* hdl/hce_req_if.sv */
interface hce_req_if
   import hce_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [BYTE_W-1:0] data_byte;

   modport source (output valid, kind, data_byte, input ready);
   modport sink   (input valid, kind, data_byte, output ready);
endinterface

/* hdl/hce_rsp_if.sv */
interface hce_rsp_if
   import hce_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              last_of_run;

   modport source (output valid, out_byte, last_of_run, input ready);
   modport sink   (input valid, out_byte, last_of_run, output ready);
endinterface

/* hdl/hce_datapath.sv */
module hce_datapath
   import hce_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [LIMIT_W-1:0] csr_wdata,
   input  logic [BYTE_W-1:0]  req_data_byte,
   input  hce_cmd_type        cmd,
   output hce_status_type     status,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [BYTE_W-1:0]  rsp_out_byte,
   output logic               rsp_last_of_run
);

   logic [BYTE_W-1:0]  store_mem [BUFFER_DEPTH];
   logic [BYTE_W-1:0]  rd_data_ff;

   logic [LIMIT_W-1:0] chunk_limit_ff;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   logic [NIB_W-1:0]   nib_ff, nib_in;
   logic [BYTE_W-1:0]  pend_ff;

   logic               rsp_valid_ff;
   logic [BYTE_W-1:0]  rsp_byte_ff, rsp_byte_in;
   logic               rsp_last_ff;

   logic [LIMIT_W-1:0] eff_limit;
   logic [HEX_W-1:0]   fill_pad;
   logic [NIB_W-1:0]   top_nib;
   logic [3:0]         nibble_cur;

   assign fill_pad   = HEX_W'(fill_ff);
   assign nibble_cur = fill_pad[{nib_ff, 2'b00} +: 4];

   // Clamp the limit into 1 .. BUFFER_DEPTH
   always_comb begin
      if (chunk_limit_ff == '0) begin
         eff_limit = LIMIT_W'(1);
      end else if (chunk_limit_ff > LIMIT_W'(BUFFER_DEPTH)) begin
         eff_limit = LIMIT_W'(BUFFER_DEPTH);
      end else begin
         eff_limit = chunk_limit_ff;
      end
   end

   // Highest non-zero nibble of the count, so no leading zero is sent
   always_comb begin
      top_nib = '0;
      for (int i = 0; i < NIB_COUNT; i++) begin
         if (fill_pad[i*4 +: 4] != 4'h0) begin
            top_nib = NIB_W'(i);
         end
      end
   end

   assign status.out_free   = !rsp_valid_ff || rsp_ready;
   assign status.fill_zero  = (fill_ff == '0);
   assign status.need_flush = (LIMIT_W'(fill_ff) >= eff_limit);
   assign status.nib_zero   = (nib_ff == '0);
   assign status.data_last  = ((FILL_W'(idx_ff) + FILL_W'(1)) == fill_ff);

   always_comb begin
      case (cmd.fill_op)
         FILL_ADD_REQ:      fill_in = fill_ff + FILL_W'(1);
         FILL_CLEAR:        fill_in = '0;
         FILL_RESTART_PEND: fill_in = FILL_W'(1);
         default:           fill_in = fill_ff;
      endcase
   end

   always_comb begin
      idx_in = idx_ff;
      nib_in = nib_ff;
      if (cmd.start_chunk) begin
         idx_in = '0;
         nib_in = top_nib;
      end
      if (cmd.idx_inc) begin
         idx_in = idx_ff + ADDR_W'(1);
      end
      if (cmd.nib_dec) begin
         nib_in = nib_ff - NIB_W'(1);
      end
   end

   always_comb begin
      case (cmd.byte_sel)
         SEL_HEX:  rsp_byte_in = hex_ascii(nibble_cur);
         SEL_CR:   rsp_byte_in = ASCII_CR;
         SEL_LF:   rsp_byte_in = ASCII_LF;
         SEL_DATA: rsp_byte_in = rd_data_ff;
         SEL_ZERO: rsp_byte_in = ASCII_ZERO;
         default:  rsp_byte_in = ASCII_ZERO;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_limit_ff <= CHUNK_LIMIT_RESET;
         fill_ff        <= '0;
         idx_ff         <= '0;
         nib_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            chunk_limit_ff <= csr_wdata;
         end
         fill_ff <= fill_in;
         idx_ff  <= idx_in;
         nib_ff  <= nib_in;
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pend_ff <= req_data_byte;
      end
      if (cmd.emit) begin
         rsp_byte_ff <= rsp_byte_in;
         rsp_last_ff <= cmd.last;
      end
   end

   // Buffer memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.fill_op == FILL_ADD_REQ) begin
         store_mem[fill_ff[ADDR_W-1:0]] <= req_data_byte;
      end else if (cmd.fill_op == FILL_RESTART_PEND) begin
         store_mem[0] <= pend_ff;
      end
      rd_data_ff <= store_mem[idx_in];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_last_of_run = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(BUFFER_DEPTH))
      else $error("fill count beyond buffer depth");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("output register overwritten while occupied");

   a_fill_add: assert property (@(posedge clock) disable iff (reset)
      (cmd.fill_op == FILL_ADD_REQ) |=> fill_ff == $past(fill_ff) + FILL_W'(1))
      else $error("data store did not advance fill count");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      cmd.idx_inc |-> (FILL_W'(idx_ff) + FILL_W'(1)) < fill_ff)
      else $error("read index advanced past buffered bytes");
`endif

endmodule

/* hdl/hce_controller.sv */
module hce_controller
   import hce_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [KIND_W-1:0] req_kind,
   output logic              req_ready,
   input  hce_status_type    status,
   output hce_cmd_type       cmd
);

   hce_state_type state_ff, state_in;
   logic          pend_ff, pend_in;
   logic          fin_ff, fin_in;
   logic          accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      pend_in  = pend_ff;
      fin_in   = fin_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_kind)
                  KIND_DATA: begin
                     if (status.need_flush) begin
                        state_in = ST_HEX;
                        pend_in  = 1'b1;
                        fin_in   = 1'b0;
                     end
                  end
                  KIND_FLUSH: begin
                     if (!status.fill_zero) begin
                        state_in = ST_HEX;
                        pend_in  = 1'b0;
                        fin_in   = 1'b0;
                     end
                  end
                  KIND_FINISH: begin
                     pend_in  = 1'b0;
                     fin_in   = 1'b1;
                     state_in = status.fill_zero ? ST_ZERO : ST_HEX;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_HEX:  if (status.out_free && status.nib_zero) state_in = ST_CR1;
         ST_CR1:  if (status.out_free) state_in = ST_LF1;
         ST_LF1:  if (status.out_free) state_in = ST_DATA;
         ST_DATA: if (status.out_free && status.data_last) state_in = ST_CR2;
         ST_CR2:  if (status.out_free) state_in = ST_LF2;
         ST_LF2:  if (status.out_free) state_in = fin_ff ? ST_ZERO : ST_IDLE;
         ST_ZERO: if (status.out_free) state_in = ST_CR3;
         ST_CR3:  if (status.out_free) state_in = ST_LF3;
         ST_LF3:  if (status.out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath commands
   always_comb begin
      cmd.emit        = 1'b0;
      cmd.byte_sel    = SEL_HEX;
      cmd.last        = 1'b0;
      cmd.fill_op     = FILL_HOLD;
      cmd.capture     = 1'b0;
      cmd.start_chunk = 1'b0;
      cmd.nib_dec     = 1'b0;
      cmd.idx_inc     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_kind)
                  KIND_DATA: begin
                     if (status.need_flush) begin
                        cmd.capture     = 1'b1;
                        cmd.start_chunk = 1'b1;
                     end else begin
                        cmd.fill_op = FILL_ADD_REQ;
                     end
                  end
                  KIND_FLUSH, KIND_FINISH: begin
                     cmd.start_chunk = !status.fill_zero;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_HEX: begin
            cmd.emit     = status.out_free;
            cmd.byte_sel = SEL_HEX;
            cmd.nib_dec  = status.out_free && !status.nib_zero;
         end
         ST_CR1, ST_CR2, ST_CR3: begin
            cmd.emit     = status.out_free;
            cmd.byte_sel = SEL_CR;
         end
         ST_LF1: begin
            cmd.emit     = status.out_free;
            cmd.byte_sel = SEL_LF;
         end
         ST_DATA: begin
            cmd.emit     = status.out_free;
            cmd.byte_sel = SEL_DATA;
            cmd.idx_inc  = status.out_free && !status.data_last;
         end
         ST_LF2: begin
            cmd.emit     = status.out_free;
            cmd.byte_sel = SEL_LF;
            cmd.last     = !fin_ff;
            if (status.out_free) begin
               cmd.fill_op = pend_ff ? FILL_RESTART_PEND : FILL_CLEAR;
            end
         end
         ST_ZERO: begin
            cmd.emit     = status.out_free;
            cmd.byte_sel = SEL_ZERO;
         end
         ST_LF3: begin
            cmd.emit     = status.out_free;
            cmd.byte_sel = SEL_LF;
            cmd.last     = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
         fin_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         fin_ff   <= fin_in;
      end
   end

endmodule

/* hdl/http_chunked_encoder.sv */
// HTTP chunked transfer encoder. Each request transfer carries a kind and a
// byte: a data byte is stored in a buffer of BUFFER_DEPTH bytes, a flush sends
// the buffered bytes as one chunk (byte count in upper-case hex without
// leading zeros, CR LF, the bytes, CR LF), and a finish flushes and then
// sends "0" CR LF. A data byte that arrives with at least chunk_limit bytes
// buffered first sends that chunk and is then stored. Kind 3 is accepted
// and dropped. Each response transfer carries one output byte; last_of_run
// marks the final byte caused by one request. A data byte that only stores
// never holds req_ready low; a request that sends bytes holds it low until
// its last byte has reached the single output register, which the response
// side drains at one byte per cycle while rsp_ready is high; the controller
// emits while that register is free. The user writes chunk_limit through
// csr_we / csr_wdata only while the block is idle; the block does not
// enforce this. 0 acts as 1 and values above the depth act as the depth.
module http_chunked_encoder
   import hce_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   hce_req_if.sink            req_chan,
   hce_rsp_if.source          rsp_chan,
   input  logic               csr_we,
   input  logic [LIMIT_W-1:0] csr_wdata
);

   // Command and status between the sequencer and the buffer datapath
   hce_cmd_type    cmd;
   hce_status_type status;

   // Sequencer: walks header, payload and trailer one byte per free slot
   hce_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_kind  (req_chan.kind),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: limit register, buffer memory, counters and output register
   hce_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .req_data_byte   (req_chan.data_byte),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_out_byte    (rsp_chan.out_byte),
      .rsp_last_of_run (rsp_chan.last_of_run)
   );

endmodule

/* verif/tb_http_chunked_encoder.sv */
`timescale 1ns / 100ps

// Self-checking bench for the chunked transfer encoder. Request transfers come
// from a queue of pending items that the stimulus process fills phase by phase;
// a clocked driver offers them on the falling edge and a clocked monitor
// checks every response transfer against the bytes predicted for each accepted
// request. The chunk limit is rewritten between phases, only with the block idle.
module tb_http_chunked_encoder;
   import hce_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 500000;
   localparam int SETTLE_CYCLES = 20;
   localparam int PRESSURE_CYCLES = 300;
   localparam int REPORT_MAX = 10;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] data_byte;
   } req_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              last_of_run;
   } chunk_byte_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_we;
   logic [LIMIT_W-1:0] csr_wdata;

   hce_req_if req_if ();
   hce_rsp_if rsp_if ();

   http_chunked_encoder DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if.sink),
      .rsp_chan  (rsp_if.source),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Half period of 1 ns gives the 2 ns clock
   always #1 clock = ~clock;

   // Items waiting to be offered, and the encoded bytes still owed by the block
   req_item_type   pending_reqs[$];
   chunk_byte_type expected_stream[$];

   // Own copy of the encoder state
   logic [BYTE_W-1:0]  model_store[BUFFER_DEPTH];
   int                 model_fill;
   logic [LIMIT_W-1:0] model_limit;

   int  fail_count;
   int  cycles_run;
   bit  req_busy;      // an item is on the request channel, not yet transferred
   int  tx_gap;        // idle cycles still owed by the sender
   int  rx_gap;        // idle cycles still owed by the receiver
   bit  idle_on;       // random idling allowed in this phase
   bit  rx_hold;       // long receiver hold-off in progress
   bit  pressure_go;   // request for the hold-off

   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_MAX) begin
         $display("MISMATCH: %s", msg);
      end
   endfunction

   function automatic int effective_limit();
      int lim;
      lim = model_limit;
      if (lim < 1) begin
         lim = 1;
      end
      if (lim > BUFFER_DEPTH) begin
         lim = BUFFER_DEPTH;
      end
      return lim;
   endfunction

   function automatic logic [BYTE_W-1:0] hex_char(input int nib);
      logic [BYTE_W-1:0] c;
      if (nib < 10) begin
         c = ASCII_ZERO + BYTE_W'(nib);
      end else begin
         c = ASCII_UPPER_A + BYTE_W'(nib - 10);
      end
      return c;
   endfunction

   // Append the buffered chunk to burst, then empty the buffer; nothing if empty
   task automatic emit_chunk(ref logic [BYTE_W-1:0] burst[$]);
      logic [BYTE_W-1:0] digits[$];
      int                n;
      if (model_fill == 0) begin
         return;
      end
      n = model_fill;
      // build the count most significant digit first, with no leading zero
      do begin
         digits.push_front(hex_char(n % 16));
         n = n / 16;
      end while (n > 0);
      foreach (digits[i]) begin
         burst.push_back(digits[i]);
      end
      burst.push_back(ASCII_CR);
      burst.push_back(ASCII_LF);
      for (int i = 0; i < model_fill; i++) begin
         burst.push_back(model_store[i]);
      end
      burst.push_back(ASCII_CR);
      burst.push_back(ASCII_LF);
      model_fill = 0;
   endtask

   // Work out the bytes caused by one accepted request and queue them up
   task automatic encode_request(input logic [KIND_W-1:0] kind,
                                 input logic [BYTE_W-1:0] value);
      logic [BYTE_W-1:0] burst[$];
      case (kind)
         KIND_DATA: begin
            // a full buffer, or one left above a lowered limit, goes out first
            if (model_fill >= effective_limit()) begin
               emit_chunk(burst);
            end
            if (model_fill < BUFFER_DEPTH) begin
               model_store[model_fill] = value;
               model_fill++;
            end
         end
         KIND_FLUSH: begin
            emit_chunk(burst);
         end
         KIND_FINISH: begin
            emit_chunk(burst);
            burst.push_back(ASCII_ZERO);
            burst.push_back(ASCII_CR);
            burst.push_back(ASCII_LF);
         end
         default: begin
            // unused kind: drop it, state untouched
         end
      endcase
      foreach (burst[i]) begin
         expected_stream.push_back('{out_byte: burst[i],
                                     last_of_run: (i == burst.size() - 1)});
      end
   endtask

   // Sender: offer the head of the queue on the falling edge and hold it
   // until it has been transferred; insert random idle bursts between items
   always @(negedge clock) begin
      if (!req_busy) begin
         if (tx_gap > 0) begin
            tx_gap--;
            req_if.valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            if (idle_on && $urandom_range(0, 3) == 0) begin
               tx_gap = $urandom_range(1, 6) - 1;
               req_if.valid <= 1'b0;
            end else begin
               req_if.valid     <= 1'b1;
               req_if.kind      <= pending_reqs[0].kind;
               req_if.data_byte <= pending_reqs[0].data_byte;
               req_busy = 1'b1;
            end
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Receiver: ready with random stall bursts, or held low during a hold-off
   always @(negedge clock) begin
      if (rx_hold) begin
         rsp_if.ready <= 1'b0;
      end else if (rx_gap > 0) begin
         rx_gap--;
         rsp_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rx_gap = $urandom_range(1, 6) - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // Long hold-off, counted here so the sender carries on offering meanwhile
   initial begin
      rx_hold = 1'b0;
      wait (pressure_go);
      rx_hold = 1'b1;
      repeat (PRESSURE_CYCLES) @(posedge clock);
      rx_hold = 1'b0;
   end

   // Rising edge: track register writes, predict each request transfer and
   // check each response transfer against the oldest owed byte
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) begin
            model_limit = csr_wdata;
         end
         if (req_if.valid && req_if.ready) begin
            encode_request(req_if.kind, req_if.data_byte);
            void'(pending_reqs.pop_front());
            req_busy = 1'b0;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_stream.size() == 0) begin
               note_failure($sformatf("unexpected byte %02h last %0b",
                                      rsp_if.out_byte, rsp_if.last_of_run));
            end else begin
               chunk_byte_type want;
               want = expected_stream.pop_front();
               if (rsp_if.out_byte !== want.out_byte) begin
                  note_failure($sformatf("out_byte expected %02h actual %02h",
                                         want.out_byte, rsp_if.out_byte));
               end
               if (rsp_if.last_of_run !== want.last_of_run) begin
                  note_failure($sformatf("last_of_run expected %0b actual %0b",
                                         want.last_of_run, rsp_if.last_of_run));
               end
            end
         end
      end
   end

   // Watchdog
   initial begin
      for (cycles_run = 0; cycles_run < CYCLE_LIMIT; cycles_run++) begin
         @(posedge clock);
      end
      $display("http_chunked_encoder regression: fail");
      $finish;
   end

   // Hold until everything queued has been transferred and answered, then
   // give the block a settling interval for requests that caused no bytes
   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_busy || expected_stream.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_chunk_limit(input logic [LIMIT_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic push_req(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] value);
      pending_reqs.push_back('{kind: kind, data_byte: value});
   endtask

   // Mostly data bytes so that buffers fill and overflow; some flushes,
   // finishes and the odd unused kind
   task automatic run_random_phase(input logic [LIMIT_W-1:0] limit, input int count,
                                   input bit idling);
      int pick;
      wait_drained();
      write_chunk_limit(limit);
      idle_on = idling;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 72) begin
            push_req(KIND_DATA, BYTE_W'($urandom));
         end else if (pick < 84) begin
            push_req(KIND_FLUSH, BYTE_W'($urandom));
         end else if (pick < 95) begin
            push_req(KIND_FINISH, BYTE_W'($urandom));
         end else begin
            push_req(KIND_UNUSED, BYTE_W'($urandom));
         end
      end
   endtask

   initial begin
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_wdata        = '0;
      req_if.valid     = 1'b0;
      req_if.kind      = '0;
      req_if.data_byte = '0;
      rsp_if.ready     = 1'b0;
      req_busy         = 1'b0;
      tx_gap           = 0;
      rx_gap           = 0;
      idle_on          = 1'b1;
      pressure_go      = 1'b0;
      fail_count       = 0;
      model_fill       = 0;
      model_limit      = CHUNK_LIMIT_RESET;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset limit: extremes of the byte, empty flush, empty finish, unused kind
      push_req(KIND_DATA, 8'h00);
      push_req(KIND_DATA, 8'hFF);
      push_req(KIND_DATA, 8'h5A);
      push_req(KIND_DATA, 8'hA5);
      push_req(KIND_FLUSH, 8'h00);
      push_req(KIND_UNUSED, 8'hFF);
      push_req(KIND_FLUSH, 8'hFF);
      push_req(KIND_FINISH, 8'h00);
      push_req(KIND_DATA, 8'h01);
      push_req(KIND_FINISH, 8'hFF);

      // Limit of zero behaves as one: every byte after the first forces a chunk
      wait_drained();
      write_chunk_limit(6'd0);
      push_req(KIND_DATA, 8'h11);
      push_req(KIND_DATA, 8'h22);
      push_req(KIND_DATA, 8'h33);
      push_req(KIND_FLUSH, 8'h00);

      // Limit above the depth, then lowered beneath the fill level
      wait_drained();
      write_chunk_limit(6'd63);
      for (int i = 0; i < 5; i++) begin
         push_req(KIND_DATA, BYTE_W'(8'hC0 + i));
      end
      wait_drained();
      write_chunk_limit(6'd2);
      push_req(KIND_DATA, 8'h77);
      push_req(KIND_FINISH, 8'h00);

      // Random phases; the first one also holds the receiver off for a long
      // stretch so the buffer fills and the request side stalls
      wait_drained();
      pressure_go = 1'b1;
      run_random_phase(6'd32, 60, 1'b1);
      run_random_phase(6'd1, 40, 1'b1);
      run_random_phase(6'd63, 60, 1'b1);
      run_random_phase(6'd16, 50, 1'b1);
      run_random_phase(6'd15, 40, 1'b1);
      run_random_phase(LIMIT_W'($urandom_range(1, 63)), 50, 1'b1);
      run_random_phase(6'd0, 30, 1'b1);
      // closing stretch at full rate, no idling on either side
      run_random_phase(6'd32, 70, 1'b0);

      wait_drained();
      repeat (50) @(posedge clock);
      if (expected_stream.size() != 0) begin
         note_failure($sformatf("%0d bytes never arrived", expected_stream.size()));
      end
      if (fail_count == 0) begin
         $display("http_chunked_encoder regression: pass");
      end else begin
         $display("http_chunked_encoder regression: fail");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/hce_pkg.sv
hdl/hce_req_if.sv
hdl/hce_rsp_if.sv
hdl/hce_datapath.sv
hdl/hce_controller.sv
hdl/http_chunked_encoder.sv
verif/tb_http_chunked_encoder.sv
